@@ rtl/iavg_pkg.sv @@
// Shared types and fixed constants for the interleaved moving average block.
// No dependencies; imported by interleaved_moving_average, iavg_checker and tb.
`timescale 1ns / 1ps
`default_nettype none

package iavg_pkg;

    // Width of the average word (signed fixed point).
    localparam int AVG_BITS = 40;

    // Width of the window length register and its value after reset.
    localparam int             WLEN_BITS  = 9;
    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 9'd8;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

`default_nettype wire

@@ rtl/interleaved_moving_average.sv @@
// Multichannel boxcar moving average: sample ring memory, running sum memory,
// and a bit-serial divider. Depends on iavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input words (sample) arrive on in_valid/in_ready and are dealt to CHANNELS
//   channels in strict round robin starting at channel 0. Each input word
//   gives exactly one output word on out_valid/out_ready: the average of the
//   channel's last window_length samples (fewer while the window fills), as
//   signed fixed point with FRAC_BITS fraction bits, truncated toward zero,
//   tagged with its channel and a row_end flag on the last channel.
//   The cfg channel writes window_length (0 acts as 1, values above
//   WINDOW_MAX act as WINDOW_MAX) and restarts averaging at channel 0 with
//   empty windows. Write it only while no word is in flight.
//   Timing: one word at a time. A word accepted at one clock edge passes
//   through the sum update, the divider load, the divider steps and the move
//   to the output register; only then is a new word taken. The restoring
//   divider, one quotient bit per cycle, sets the rate.
//   Reset: window length 8, all sums empty, channel 0. The sample ring is not
//   cleared; entries are read only after they were written.
//   Stall: one result waits in the output register while the next word is
//   accepted and computed; that word then holds until the register frees.
module interleaved_moving_average
    import iavg_pkg::*;
#(
    parameter int WINDOW_MAX  = 256,
    parameter int CHANNELS    = 5,
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 8,
    localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [WLEN_BITS-1:0]          window_length,
    // input words
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    // output words
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [AVG_BITS-1:0]         average,
    output logic [CH_BITS-1:0]                 channel,
    output logic                               row_end
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int PB       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int KW       = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int DIV_BITS = SUM_BITS + FRAC_BITS;
    localparam int CW       = $clog2(DIV_BITS + 1);
    localparam int RDEPTH   = CHANNELS * WINDOW_MAX;
    localparam int RA_BITS  = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
    localparam int QW       = (DIV_BITS > AVG_BITS) ? DIV_BITS : AVG_BITS;

    localparam logic [KW-1:0] WIN_RESET =
        (32'(WLEN_RESET) > 32'(WINDOW_MAX)) ? KW'(WINDOW_MAX) : KW'(WLEN_RESET);
    localparam logic [CH_BITS-1:0] CH_LAST = CH_BITS'(CHANNELS - 1);
    localparam logic [QW-1:0] LIM_POS = QW'({1'b0, {(AVG_BITS-1){1'b1}}});
    localparam logic [QW-1:0] LIM_NEG = QW'({1'b1, {(AVG_BITS-1){1'b0}}});

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [KW-1:0]          win_reg;         // effective window length
    logic [CH_BITS-1:0]     ch_reg;          // channel whose turn it is
    logic [PB-1:0]          pos_reg;         // ring slot, shared by all channels
    logic [KW-1:0]          fill_reg;        // completed rows, saturates at window
    logic [CHANNELS-1:0]    sum_vld_reg;     // running sum entry holds data

    logic signed [SAMPLE_BITS-1:0] smp_reg;  // sample of the word in flight
    logic [RA_BITS-1:0]     addr_reg;
    logic [CH_BITS-1:0]     item_ch_reg;

    logic signed [SAMPLE_BITS-1:0] ring_rd_reg;
    logic signed [SUM_BITS-1:0]    sum_rd_reg;
    logic signed [SUM_BITS-1:0]    sum_reg;  // new running sum of the word

    logic [KW-1:0]          dvsr_reg;
    logic [KW-1:0]          rem_reg;
    logic [DIV_BITS-1:0]    quot_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   neg_reg;

    logic                   out_valid_reg;
    logic signed [AVG_BITS-1:0] average_reg;
    logic [CH_BITS-1:0]     channel_reg;
    logic                   row_end_reg;

    // Memories: sample ring and per-channel running sums.
    logic signed [SAMPLE_BITS-1:0] ring_mem [RDEPTH];
    logic signed [SUM_BITS-1:0]    sum_mem  [CHANNELS];

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_acc, out_take, cfg_acc, out_load;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_take  = out_valid_reg && out_ready;
    assign cfg_acc   = cfg_valid;
    // Move a finished quotient into the output register once it is free.
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign out_valid = out_valid_reg;
    assign average   = average_reg;
    assign channel   = channel_reg;
    assign row_end   = row_end_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_READ;
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == CW'(1)) state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Address of the ring slot for the current channel
    // ------------------------------------------------------------------
    logic [RA_BITS-1:0] ring_addr;
    assign ring_addr = RA_BITS'(RA_BITS'(ch_reg) * RA_BITS'(WINDOW_MAX)) + RA_BITS'(pos_reg);

    // ------------------------------------------------------------------
    // Sum update, done in the cycle after the memory read
    // ------------------------------------------------------------------
    logic                       full;
    logic signed [SUM_BITS-1:0] old_sum, old_smp, new_sum;
    logic [KW-1:0]              k_val;

    assign full    = (fill_reg >= win_reg);
    assign old_sum = sum_vld_reg[item_ch_reg] ? sum_rd_reg : '0;
    assign old_smp = full ? SUM_BITS'(ring_rd_reg) : '0;
    assign new_sum = old_sum + SUM_BITS'(smp_reg) - old_smp;
    assign k_val   = full ? win_reg : KW'(fill_reg + KW'(1));

    // Advance the channel on every word; ring slot and fill level at the end of a row.
    logic [KW-1:0] pos_inc;
    assign pos_inc = KW'(pos_reg) + KW'(1);

    // ------------------------------------------------------------------
    // Divider step (restoring, one quotient bit per cycle)
    // ------------------------------------------------------------------
    logic [KW:0]          shifted, trial;
    logic                 q_bit;
    logic [SUM_BITS-1:0]  mag;

    assign shifted = {rem_reg, quot_reg[DIV_BITS-1]};
    assign trial   = shifted - {1'b0, dvsr_reg};
    assign q_bit   = !trial[KW];
    assign mag     = sum_reg[SUM_BITS-1] ? SUM_BITS'(-sum_reg) : SUM_BITS'(sum_reg);

    // Saturate and restore the sign.
    logic [QW-1:0]       q_ext, q_sat;
    logic [AVG_BITS-1:0] avg_mag;
    assign q_ext   = QW'(quot_reg);
    assign q_sat   = neg_reg ? ((q_ext > LIM_NEG) ? LIM_NEG : q_ext)
                             : ((q_ext > LIM_POS) ? LIM_POS : q_ext);
    assign avg_mag = q_sat[AVG_BITS-1:0];

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            win_reg       <= WIN_RESET;
            ch_reg        <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            sum_vld_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_acc)
            begin
                // Clamp the window into 1 .. WINDOW_MAX and restart the run.
                if (window_length == '0)
                    win_reg <= KW'(1);
                else if (32'(window_length) > 32'(WINDOW_MAX))
                    win_reg <= KW'(WINDOW_MAX);
                else
                    win_reg <= KW'(window_length);
                ch_reg      <= '0;
                pos_reg     <= '0;
                fill_reg    <= '0;
                sum_vld_reg <= '0;
            end
            else if (state_reg == ST_READ)
            begin
                sum_vld_reg[item_ch_reg] <= 1'b1;
                if (ch_reg == CH_LAST)
                begin
                    ch_reg  <= '0;
                    pos_reg <= (pos_inc >= win_reg) ? '0 : PB'(pos_inc);
                    if (!full)
                        fill_reg <= KW'(fill_reg + KW'(1));
                end
                else
                begin
                    ch_reg <= CH_BITS'(ch_reg + CH_BITS'(1));
                end
            end

            if (state_reg == ST_LOAD)
                cnt_reg <= CW'(DIV_BITS);
            else if (state_reg == ST_DIV)
                cnt_reg <= CW'(cnt_reg - CW'(1));

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            smp_reg     <= sample;
            addr_reg    <= ring_addr;
            item_ch_reg <= ch_reg;
        end

        if (state_reg == ST_READ)
        begin
            sum_reg  <= new_sum;
            dvsr_reg <= k_val;
        end

        if (state_reg == ST_LOAD)
        begin
            neg_reg  <= sum_reg[SUM_BITS-1];
            rem_reg  <= '0;
            quot_reg <= DIV_BITS'(mag) << FRAC_BITS;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg  <= q_bit ? trial[KW-1:0] : shifted[KW-1:0];
            quot_reg <= {quot_reg[DIV_BITS-2:0], q_bit};
        end

        if (out_load)
        begin
            average_reg <= neg_reg ? AVG_BITS'(-avg_mag) : avg_mag;
            channel_reg <= item_ch_reg;
            row_end_reg <= (item_ch_reg == CH_LAST);
        end
    end

    // ------------------------------------------------------------------
    // Memories: read on accept, written back in the same cycle as the sum update
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            ring_mem[addr_reg] <= smp_reg;
        if (in_acc)
            ring_rd_reg <= ring_mem[ring_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            sum_mem[item_ch_reg] <= new_sum;
        if (in_acc)
            sum_rd_reg <= sum_mem[ch_reg];
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_reg)
        else $error("fill level above window length");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        KW'(pos_reg) < win_reg)
        else $error("ring slot outside window");

    a_ch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ch_reg) < 32'(CHANNELS))
        else $error("channel index out of range");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < dvsr_reg)
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

@@ dv/iavg_checker.sv @@
// Scoreboard for interleaved_moving_average: watches the window, sample and
// average channels, predicts every average and compares it field by field.
// Depends on iavg_pkg for the word widths and the window reset value.
`timescale 1ns / 1ps

module iavg_checker
    import iavg_pkg::*;
#(
    parameter int WINDOW_MAX  = 256,
    parameter int CHANNELS    = 5,
    parameter int SAMPLE_BITS = 32,
    parameter int FRAC_BITS   = 8,
    parameter int CH_BITS     = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [WLEN_BITS-1:0]          window_length,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [AVG_BITS-1:0]    average,
    input  logic [CH_BITS-1:0]            channel,
    input  logic                          row_end,
    output int                            errors,
    output int                            averages_seen,
    output int                            averages_pending
);

    typedef struct packed {
        logic signed [AVG_BITS-1:0] average;
        logic [CH_BITS-1:0]         channel;
        logic                       row_end;
    } avg_word_t;

    avg_word_t expected_averages[$];

    // Own copy of the block state.
    logic [WLEN_BITS-1:0]          wlen;
    logic signed [SAMPLE_BITS-1:0] history [CHANNELS*WINDOW_MAX];
    logic signed [AVG_BITS-1:0]    run_sum [CHANNELS];
    int unsigned                   next_ch;
    int unsigned                   oldest_slot;
    int unsigned                   rows_filled;

    function automatic int unsigned active_window();
        if (wlen == '0)
            return 1;
        if (32'(wlen) > WINDOW_MAX)
            return WINDOW_MAX;
        return 32'(wlen);
    endfunction

    // Sum * 2^FRAC_BITS / count, truncated toward zero, saturated to the word.
    function automatic logic [AVG_BITS-1:0] scaled_quotient(
        input logic signed [AVG_BITS-1:0] total,
        input int unsigned                count
    );
        logic signed [63:0] wide;
        logic [63:0]        mag;
        logic [63:0]        quo;
        logic [63:0]        rem;
        logic [63:0]        lim;
        logic [63:0]        val;
        logic               neg;
        wide = 64'(total);
        neg  = wide[63];
        mag  = neg ? -wide : wide;
        quo  = mag / 64'(count);
        rem  = mag % 64'(count);
        lim  = neg ? (64'd1 << (AVG_BITS - 1)) : (64'd1 << (AVG_BITS - 1)) - 64'd1;
        if (quo > lim)
            val = lim;
        else
        begin
            val = (quo << FRAC_BITS) + ((rem << FRAC_BITS) / 64'(count));
            if (val > lim)
                val = lim;
        end
        if (neg)
            val = -val;
        return val[AVG_BITS-1:0];
    endfunction

    task automatic restart_windows();
        for (int c = 0; c < CHANNELS; c++)
            run_sum[c] = '0;
        next_ch     = 0;
        oldest_slot = 0;
        rows_filled = 0;
    endtask

    task automatic predict_average(input logic signed [SAMPLE_BITS-1:0] x);
        int unsigned w;
        int unsigned ch;
        int unsigned pos;
        int unsigned k;
        int unsigned slot;
        avg_word_t   exp_word;
        w    = active_window();
        ch   = next_ch;
        pos  = oldest_slot;
        slot = ch * WINDOW_MAX + pos;
        if (rows_filled < w)
        begin
            run_sum[ch] = run_sum[ch] + AVG_BITS'(x);
            k = rows_filled + 1;
        end
        else
        begin
            run_sum[ch] = run_sum[ch] + AVG_BITS'(x) - AVG_BITS'(history[slot]);
            k = w;
        end
        history[slot] = x;
        exp_word.average = scaled_quotient(run_sum[ch], k);
        exp_word.channel = CH_BITS'(ch);
        exp_word.row_end = (ch == CHANNELS - 1);
        expected_averages.push_back(exp_word);
        if (ch == CHANNELS - 1)
        begin
            next_ch = 0;
            pos++;
            if (pos >= w)
                pos = 0;
            if (rows_filled < w)
                rows_filled++;
        end
        else
            next_ch = ch + 1;
        oldest_slot = pos;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        avg_word_t want;
        if (!rst_n)
        begin
            wlen = WLEN_RESET;
            restart_windows();
            expected_averages.delete();
            errors        = 0;
            averages_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_averages.size() == 0)
                begin
                    $error("average word with none expected: average %0d channel %0d",
                           average, channel);
                    errors++;
                end
                else
                begin
                    want = expected_averages.pop_front();
                    averages_seen++;
                    if (average !== want.average)
                    begin
                        $error("average: expected %0d, got %0d", want.average, average);
                        errors++;
                    end
                    if (channel !== want.channel)
                    begin
                        $error("channel: expected %0d, got %0d", want.channel, channel);
                        errors++;
                    end
                    if (row_end !== want.row_end)
                    begin
                        $error("row_end: expected %0d, got %0d", want.row_end, row_end);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                wlen = window_length;
                restart_windows();
            end
            if (in_valid && in_ready)
                predict_average(sample);
        end
        averages_pending = expected_averages.size();
    end

endmodule

@@ dv/tb.sv @@
// Testbench top for interleaved_moving_average: drives samples, window writes
// and output back-pressure, and reports the verdict.
// Depends on iavg_pkg, interleaved_moving_average and iavg_checker.
`timescale 1ns / 1ps

module tb;
    import iavg_pkg::*;

    localparam int SAMPLE_BITS = 32;
    localparam int CH_BITS     = 3;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          cfg_valid     = 1'b0;
    logic [WLEN_BITS-1:0]          window_length = '0;
    logic                          in_valid      = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample        = '0;
    logic                          out_ready     = 1'b0;
    logic                          cfg_ready;
    logic                          in_ready;
    logic                          out_valid;
    logic signed [AVG_BITS-1:0]    average;
    logic [CH_BITS-1:0]            channel;
    logic                          row_end;

    int errors;
    int averages_seen;
    int averages_pending;

    // Idle odds out of a hundred for the sample sender and the average receiver.
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int window_writes = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    interleaved_moving_average i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_length (window_length),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .average       (average),
        .channel       (channel),
        .row_end       (row_end)
    );

    iavg_checker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CH_BITS     (CH_BITS)
    ) i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .window_length    (window_length),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .average          (average),
        .channel          (channel),
        .row_end          (row_end),
        .errors           (errors),
        .averages_seen    (averages_seen),
        .averages_pending (averages_pending)
    );

    // Receiver: drop ready at random, at the current stall odds.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= out_stall_pct);

    // Mix of extremes, small values around zero and full-range words.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom_range(2000) - 1000;
            default: return $urandom();
        endcase
    endfunction

    // Offer one sample word and hold it until accepted. Valid stays high into
    // the next word unless an idle gap is drawn, so no double update per step.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < in_idle_pct);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Hold the sender back until every expected average has come out. The
    // extra edge lets the checker log the last accepted word first.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (averages_pending == 0);
    endtask

    // Write the window register with the block idle; this restarts all
    // channels at channel 0 with empty windows.
    task automatic set_window(input logic [WLEN_BITS-1:0] value);
        drain();
        cfg_valid     <= 1'b1;
        window_length <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        window_writes++;
    endtask

    // One random phase: a window setting, a word count and an idle mix.
    // Pause the sender once mid-phase until all averages are out.
    task automatic run_phase(input logic [WLEN_BITS-1:0] wlen, input int count,
                             input int idle_pct, input int stall_pct);
        set_window(wlen);
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                drain();
            send_sample(pick_sample());
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window of 8: extremes while the windows are still filling.
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_0001);

        // Window zero acts as one: every sample replaces the last.
        set_window(9'd0);
        repeat (5) send_sample(32'h8000_0000);
        repeat (5) send_sample(32'h7FFF_FFFF);

        // Window of two: fill with the maximum, then push one row of the minimum.
        set_window(9'd2);
        repeat (10) send_sample(32'h7FFF_FFFF);
        repeat (5) send_sample(32'h8000_0000);

        // Random part: several windows, including above the maximum (acts as
        // the maximum) and the maximum itself, under each idle mix.
        run_phase(9'd3, 90, 0, 0);
        run_phase(9'd1, 50, 75, 0);
        run_phase(9'd16, 120, 0, 75);
        run_phase(9'd5, 90, 7, 7);
        run_phase(9'd511, 50, 75, 0);
        run_phase(9'd256, 50, 0, 0);

        // Let any stray word show up before the verdict.
        drain();
        repeat (60) @(posedge clk);

        $display("Covered %0d averages over %0d window settings, all five channels,",
                 averages_seen, window_writes + 1);
        $display("with free-running, sender-idle, receiver-stall and mixed traffic.");
        if (errors == 0 && averages_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
rtl/iavg_pkg.sv
rtl/interleaved_moving_average.sv
dv/iavg_checker.sv
dv/tb.sv
